// ----- hdl/sclb_pkg.sv -----
// Shared types, codes and scancode tables for the scancode line buffer.
package sclb_pkg;

    localparam int BUFFER_DEPTH_DEF = 1024;
    localparam int CHAR_W           = 7;
    localparam int FILL_W           = 10;
    localparam int ADDR_IN_W        = 10;
    localparam int WIDE_W           = 17;
    localparam int RELEASE_BIT      = 7;

    localparam logic [7:0] SC_PREFIX     = 8'hE0;
    localparam logic [7:0] SC_F12        = 8'h58;
    localparam logic [7:0] SC_LSHIFT     = 8'h2A;
    localparam logic [7:0] SC_RSHIFT     = 8'h36;
    localparam logic [7:0] SC_LSHIFT_REL = 8'hAA;
    localparam logic [7:0] SC_RSHIFT_REL = 8'hB6;

    localparam logic [CHAR_W-1:0] CH_NONE      = 7'h00;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 7'h08;

    typedef enum logic [1:0] {
        OP_SCAN    = 2'd0,
        OP_CLEAR   = 2'd1,
        OP_READ    = 2'd2,
        OP_CLR_F12 = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ACT_IGNORED   = 3'd0,
        ACT_PREFIX    = 3'd1,
        ACT_F12       = 3'd2,
        ACT_SHIFT     = 3'd3,
        ACT_STORED    = 3'd4,
        ACT_BACKSPACE = 3'd5,
        ACT_DROPPED   = 3'd6,
        ACT_OP_DONE   = 3'd7
    } t_action;

    typedef enum logic [2:0] {
        ST_INIT_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_UPDATE,
        ST_OP_CLEAR,
        ST_RESULT
    } t_state;

    typedef struct packed {
        t_op                  operation;
        logic [7:0]           scan_byte;
        logic [ADDR_IN_W-1:0] read_address;
    } t_in_item;

    typedef struct packed {
        t_action           action;
        logic [CHAR_W-1:0] char_code;
        logic [FILL_W-1:0] fill_index;
        logic              shift_active;
        logic              f12_request;
        logic [CHAR_W-1:0] read_char;
    } t_out_item;

    typedef struct packed {
        logic capture;
        logic decode;
        logic update;
        logic clear_step;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        t_op  op;
        logic clear_last;
    } t_dp_status;

    function automatic logic [CHAR_W-1:0] plain_char(input logic [6:0] code);
        logic [CHAR_W-1:0] ch;
        case (code)
            7'd2:  ch = 7'h31;
            7'd3:  ch = 7'h32;
            7'd4:  ch = 7'h33;
            7'd5:  ch = 7'h34;
            7'd6:  ch = 7'h35;
            7'd7:  ch = 7'h36;
            7'd8:  ch = 7'h37;
            7'd9:  ch = 7'h38;
            7'd10: ch = 7'h39;
            7'd11: ch = 7'h30;
            7'd12: ch = 7'h2D;
            7'd13: ch = 7'h3D;
            7'd14: ch = 7'h08;
            7'd15: ch = 7'h09;
            7'd16: ch = 7'h71;
            7'd17: ch = 7'h77;
            7'd18: ch = 7'h65;
            7'd19: ch = 7'h72;
            7'd20: ch = 7'h74;
            7'd21: ch = 7'h79;
            7'd22: ch = 7'h75;
            7'd23: ch = 7'h69;
            7'd24: ch = 7'h6F;
            7'd25: ch = 7'h70;
            7'd26: ch = 7'h5B;
            7'd27: ch = 7'h5D;
            7'd28: ch = 7'h0A;
            7'd30: ch = 7'h61;
            7'd31: ch = 7'h73;
            7'd32: ch = 7'h64;
            7'd33: ch = 7'h66;
            7'd34: ch = 7'h67;
            7'd35: ch = 7'h68;
            7'd36: ch = 7'h6A;
            7'd37: ch = 7'h6B;
            7'd38: ch = 7'h6C;
            7'd39: ch = 7'h3B;
            7'd40: ch = 7'h27;
            7'd41: ch = 7'h60;
            7'd43: ch = 7'h5C;
            7'd44: ch = 7'h7A;
            7'd45: ch = 7'h78;
            7'd46: ch = 7'h63;
            7'd47: ch = 7'h76;
            7'd48: ch = 7'h62;
            7'd49: ch = 7'h6E;
            7'd50: ch = 7'h6D;
            7'd51: ch = 7'h2C;
            7'd52: ch = 7'h2E;
            7'd53: ch = 7'h2F;
            7'd55: ch = 7'h2A;
            7'd57: ch = 7'h20;
            7'd71: ch = 7'h37;
            7'd72: ch = 7'h38;
            7'd73: ch = 7'h39;
            7'd74: ch = 7'h2D;
            7'd75: ch = 7'h34;
            7'd76: ch = 7'h35;
            7'd77: ch = 7'h36;
            7'd78: ch = 7'h2B;
            7'd79: ch = 7'h31;
            7'd80: ch = 7'h32;
            7'd81: ch = 7'h33;
            7'd82: ch = 7'h30;
            7'd83: ch = 7'h2E;
            default: ch = CH_NONE;
        endcase
        return ch;
    endfunction

    function automatic logic [CHAR_W-1:0] shift_char(input logic [6:0] code);
        logic [CHAR_W-1:0] ch;
        case (code)
            7'd2:  ch = 7'h21;
            7'd3:  ch = 7'h40;
            7'd4:  ch = 7'h23;
            7'd5:  ch = 7'h24;
            7'd6:  ch = 7'h25;
            7'd7:  ch = 7'h5E;
            7'd8:  ch = 7'h26;
            7'd9:  ch = 7'h2A;
            7'd10: ch = 7'h28;
            7'd11: ch = 7'h29;
            7'd12: ch = 7'h5F;
            7'd13: ch = 7'h2B;
            7'd16: ch = 7'h51;
            7'd17: ch = 7'h57;
            7'd18: ch = 7'h45;
            7'd19: ch = 7'h52;
            7'd20: ch = 7'h54;
            7'd21: ch = 7'h59;
            7'd22: ch = 7'h55;
            7'd23: ch = 7'h49;
            7'd24: ch = 7'h4F;
            7'd25: ch = 7'h50;
            7'd26: ch = 7'h7B;
            7'd27: ch = 7'h7D;
            7'd30: ch = 7'h41;
            7'd31: ch = 7'h53;
            7'd32: ch = 7'h44;
            7'd33: ch = 7'h46;
            7'd34: ch = 7'h47;
            7'd35: ch = 7'h48;
            7'd36: ch = 7'h4A;
            7'd37: ch = 7'h4B;
            7'd38: ch = 7'h4C;
            7'd39: ch = 7'h3A;
            7'd40: ch = 7'h22;
            7'd41: ch = 7'h7E;
            7'd43: ch = 7'h7C;
            7'd44: ch = 7'h5A;
            7'd45: ch = 7'h58;
            7'd46: ch = 7'h43;
            7'd47: ch = 7'h56;
            7'd48: ch = 7'h42;
            7'd49: ch = 7'h4E;
            7'd50: ch = 7'h4D;
            7'd51: ch = 7'h3C;
            7'd52: ch = 7'h3E;
            7'd53: ch = 7'h3F;
            default: ch = plain_char(code);
        endcase
        return ch;
    endfunction

endpackage

// ----- hdl/sclb_dp.sv -----
// Datapath of the scancode line buffer: decode, flags, fill index, line memory.
module sclb_dp #(
    parameter int BUFFER_DEPTH = sclb_pkg::BUFFER_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sclb_pkg::t_dp_cmd     i_cmd,
    output sclb_pkg::t_dp_status  o_status,
    input  sclb_pkg::t_in_item    i_in_item,
    output sclb_pkg::t_out_item   o_out_item
);
    import sclb_pkg::*;

    localparam int              AW       = $clog2(BUFFER_DEPTH);
    localparam logic [AW-1:0]   LAST_IDX = AW'(BUFFER_DEPTH - 1);

    logic [CHAR_W-1:0] r_mem [BUFFER_DEPTH];
    logic [CHAR_W-1:0] r_mem_q;
    t_in_item          r_in;
    t_action           r_action, n_action;
    logic [CHAR_W-1:0] r_ch, n_ch;
    logic [AW-1:0]     r_widx;
    logic [AW-1:0]     r_clr_addr;
    logic              r_shift;
    logic              r_f12;
    t_out_item         r_out;

    logic [WIDE_W-1:0] w_addr_wide;
    logic [WIDE_W-1:0] w_widx_wide;
    logic              w_in_range;
    logic [CHAR_W-1:0] w_table_ch;
    logic              w_mem_we;
    logic              w_clear_last;

    assign w_addr_wide  = WIDE_W'(r_in.read_address);
    assign w_widx_wide  = WIDE_W'(r_widx);
    assign w_in_range   = w_addr_wide < WIDE_W'(BUFFER_DEPTH);
    assign w_clear_last = r_clr_addr == LAST_IDX;
    assign w_table_ch   = r_shift ? shift_char(r_in.scan_byte[6:0])
                                  : plain_char(r_in.scan_byte[6:0]);
    assign w_mem_we     = i_cmd.update &&
                          (r_action == ACT_STORED ||
                           (r_action == ACT_BACKSPACE && r_widx != '0));

    always_comb begin
        n_action = ACT_OP_DONE;
        n_ch     = CH_NONE;
        if (r_in.operation == OP_SCAN) begin
            if (r_in.scan_byte == SC_PREFIX) begin
                n_action = ACT_PREFIX;
            end else if (r_in.scan_byte == SC_F12) begin
                n_action = ACT_F12;
            end else if (r_in.scan_byte[RELEASE_BIT]) begin
                n_action = (r_in.scan_byte == SC_LSHIFT_REL ||
                            r_in.scan_byte == SC_RSHIFT_REL) ? ACT_SHIFT : ACT_IGNORED;
            end else if (r_in.scan_byte == SC_LSHIFT || r_in.scan_byte == SC_RSHIFT) begin
                n_action = ACT_SHIFT;
            end else begin
                n_ch = w_table_ch;
                if (w_table_ch == CH_NONE) begin
                    n_action = ACT_IGNORED;
                end else if (w_table_ch == CH_BACKSPACE) begin
                    n_action = ACT_BACKSPACE;
                end else if (r_widx != LAST_IDX) begin
                    n_action = ACT_STORED;
                end else begin
                    n_action = ACT_DROPPED;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in <= i_in_item;
        end
        if (i_cmd.decode) begin
            r_action <= n_action;
            r_ch     <= n_ch;
        end
        if (i_cmd.load_out) begin
            r_out.action       <= r_action;
            r_out.char_code    <= r_ch;
            r_out.fill_index   <= w_widx_wide[FILL_W-1:0];
            r_out.shift_active <= r_shift;
            r_out.f12_request  <= r_f12;
            r_out.read_char    <= (r_in.operation == OP_READ && w_in_range) ? r_mem_q : CH_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_widx     <= '0;
            r_clr_addr <= '0;
            r_shift    <= 1'b0;
            r_f12      <= 1'b0;
        end else if (i_cmd.clear_step) begin
            r_widx     <= '0;
            r_clr_addr <= w_clear_last ? '0 : r_clr_addr + AW'(1);
        end else if (i_cmd.update) begin
            case (r_action)
                ACT_F12: begin
                    r_f12 <= 1'b1;
                end
                ACT_SHIFT: begin
                    r_shift <= !r_in.scan_byte[RELEASE_BIT];
                end
                ACT_STORED: begin
                    r_widx <= r_widx + AW'(1);
                end
                ACT_BACKSPACE: begin
                    if (r_widx != '0) begin
                        r_widx <= r_widx - AW'(1);
                    end
                end
                ACT_OP_DONE: begin
                    if (r_in.operation == OP_CLR_F12) begin
                        r_f12 <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_step) begin
            r_mem[r_clr_addr] <= CH_NONE;
        end else if (w_mem_we) begin
            r_mem[r_widx] <= r_ch;
        end
        if (i_cmd.decode) begin
            r_mem_q <= r_mem[w_addr_wide[AW-1:0]];
        end
    end

    assign o_status.op         = r_in.operation;
    assign o_status.clear_last = w_clear_last;
    assign o_out_item          = r_out;

`ifndef SYNTHESIS
    a_widx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_widx <= LAST_IDX)
        else $error("fill index beyond last entry");

    a_clear_zeroes_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.clear_step && w_clear_last) |=> (r_widx == '0 && r_clr_addr == '0))
        else $error("clear sweep left index or sweep address nonzero");
`endif

endmodule

// ----- hdl/sclb_ctrl.sv -----
// Controller state machine of the scancode line buffer.
module sclb_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    input  sclb_pkg::t_dp_status  i_status,
    output sclb_pkg::t_dp_cmd     o_cmd
);
    import sclb_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_INIT_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_status.clear_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_DECODE;
                end
            end
            ST_DECODE: begin
                o_cmd.decode = 1'b1;
                n_state      = (i_status.op == OP_CLEAR) ? ST_OP_CLEAR : ST_UPDATE;
            end
            ST_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = ST_RESULT;
            end
            ST_OP_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_status.clear_last) begin
                    n_state = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    a_accept_to_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_state == ST_DECODE)
        else $error("accepted transaction did not enter decode");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> (!r_out_valid || i_out_ready))
        else $error("output register overwritten before transaction completed");

    a_clear_then_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OP_CLEAR && i_status.clear_last) |=> r_state == ST_RESULT)
        else $error("buffer clear did not report a result");
`endif

endmodule

// ----- hdl/scancode_line_buffer_core.sv -----
// Top level of the scancode line buffer: controller and datapath.
// Each transaction carries one operation (scancode, clear buffer, read entry,
// clear F12 flag) and returns exactly one result. A scancode, read or F12 clear
// passes through accept, decode with the memory read, update with the memory
// write and result load, which waits until the output register is empty or
// being taken; the line memory has one write and one read port, and the
// controller handles one transaction at a time. A clear-buffer operation sweeps
// the memory one entry per cycle between decode and result load. After reset
// the same sweep runs over the whole memory before the first transaction is
// accepted. A finished result waits in the output register while the next transaction is accepted.
module scancode_line_buffer_core #(
    parameter int BUFFER_DEPTH = sclb_pkg::BUFFER_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  sclb_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output sclb_pkg::t_out_item  o_out_item
);
    import sclb_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    sclb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    sclb_dp #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .i_in_item  (i_in_item),
        .o_out_item (o_out_item)
    );

endmodule
